// ===== rtl/pfx_pkg.sv =====
// Shared types, codes and defaults of the postfix integer evaluator.
package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int CAUSE_W         = 2;
    localparam int DIV_STEPS       = DATA_W;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic KIND_OPERAND  = 1'b0;
    localparam logic KIND_OPERATOR = 1'b1;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NONNUM = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_DIV0   = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_MISUSE = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_DFIX = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic div_fix;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_req;
        logic div_done;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/pfx_if.sv =====
// Valid/ready channel interfaces for input items and result words.
interface pfx_item_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic signed [pfx_pkg::DATA_W-1:0] operand_value;
    logic                            is_number;
    logic        [pfx_pkg::OP_W-1:0] op_code;
    logic                            last;

    modport source (output valid, kind, operand_value, is_number, op_code, last,
                    input ready);
    modport sink   (input valid, kind, operand_value, is_number, op_code, last,
                    output ready);
endinterface

interface pfx_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfx_pkg::DATA_W-1:0]  value;
    logic                               ok;
    logic        [pfx_pkg::CAUSE_W-1:0] cause;

    modport source (output valid, value, ok, cause, input ready);
    modport sink   (input valid, value, ok, cause, output ready);
endinterface

// ===== rtl/pfx_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
module pfx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pfx_pkg::t_sts  i_sts,
    output pfx_pkg::t_cmd  o_cmd
);

    pfx_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfx_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            pfx_pkg::S_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = pfx_pkg::S_EXEC;
                end
            end
            pfx_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_sts.div_req ? pfx_pkg::S_DIV : pfx_pkg::S_FIN;
            end
            pfx_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = pfx_pkg::S_DFIX;
                end
            end
            pfx_pkg::S_DFIX: begin
                o_cmd.div_fix = 1'b1;
                n_state = pfx_pkg::S_FIN;
            end
            pfx_pkg::S_FIN: begin
                // A final item waits here until the result register is free.
                if (!(i_sts.last && i_sts.out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state = pfx_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfx_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pfx_dp.sv =====
// Datapath: item registers, evaluation stack, ALU, serial divider, result register.
module pfx_dp #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfx_pkg::t_cmd                     i_cmd,
    output pfx_pkg::t_sts                     o_sts,
    input  logic                              i_kind,
    input  logic        [pfx_pkg::DATA_W-1:0] i_operand_value,
    input  logic                              i_is_number,
    input  logic        [pfx_pkg::OP_W-1:0]   i_op_code,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic        [pfx_pkg::DATA_W-1:0] o_value,
    output logic        [pfx_pkg::CAUSE_W-1:0] o_cause
);

    localparam int DW = pfx_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
    localparam logic [LW-1:0] ONE_L   = LW'(1);
    localparam logic [LW-1:0] TWO_L   = LW'(2);

    // Latched item.
    logic                    r_kind;
    logic [DW-1:0]           r_opnd;
    logic                    r_isnum;
    logic [pfx_pkg::OP_W-1:0] r_op;
    logic                    r_last;

    // Stack: the top entry lives in r_tos, the entries below it in the memory.
    logic [DW-1:0] r_mem [STACK_DEPTH];
    logic [DW-1:0] r_rd;
    logic [DW-1:0] r_tos, n_tos;
    logic [LW-1:0] r_level, n_level;
    logic          r_abort, n_abort;
    logic          r_div0, n_div0;
    logic          r_mis, n_mis;
    logic          w_wr_en;
    logic [LW-1:0] w_lm1, w_lm2;

    // Serial divider on magnitudes.
    logic [DW-1:0]                r_dq;
    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_b;
    logic [pfx_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                         r_sl, r_sr, r_isrem;
    logic [DW:0]                  w_sh;
    logic                         w_ge;
    logic [DW:0]                  w_sub;

    logic [DW-1:0] w_prod;
    logic [DW-1:0] w_lmag, w_rmag;
    logic          w_is_divop;

    logic                        r_out_valid;
    logic [DW-1:0]               r_out_value;
    logic [pfx_pkg::CAUSE_W-1:0] r_out_cause;

    assign w_lm1 = r_level - ONE_L;
    assign w_lm2 = r_level - TWO_L;
    assign w_prod = r_rd * r_tos;
    assign w_lmag = r_rd[DW-1] ? (~r_rd + 1'b1) : r_rd;
    assign w_rmag = r_tos[DW-1] ? (~r_tos + 1'b1) : r_tos;

    always_comb begin
        case (r_op) inside
            pfx_pkg::OP_DIV, pfx_pkg::OP_REM: w_is_divop = 1'b1;
            default:                          w_is_divop = 1'b0;
        endcase
    end

    assign o_sts.div_req  = !r_abort && (r_kind == pfx_pkg::KIND_OPERATOR) &&
                            (r_level >= TWO_L) && w_is_divop && (r_tos != '0);
    assign o_sts.div_done = (r_cnt == pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS - 1));
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_opnd  <= i_operand_value;
            r_isnum <= i_is_number;
            r_op    <= i_op_code;
            r_last  <= i_last;
        end
    end

    // The read address tracks the current level; the read data is registered in r_rd.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_lm1[AW-1:0]] <= r_tos;
        end
        r_rd <= r_mem[w_lm2[AW-1:0]];
    end

    always_comb begin
        n_tos   = r_tos;
        n_level = r_level;
        n_abort = r_abort;
        n_div0  = r_div0;
        n_mis   = r_mis;
        w_wr_en = 1'b0;
        if (i_cmd.exec && !r_abort) begin
            if (r_kind == pfx_pkg::KIND_OPERAND) begin
                if (!r_isnum) begin
                    n_abort = 1'b1;
                end else if (r_level >= DEPTH_L) begin
                    n_mis = 1'b1;
                end else begin
                    w_wr_en = (r_level != '0);
                    n_tos   = r_opnd;
                    n_level = r_level + ONE_L;
                end
            end else if (r_level < TWO_L) begin
                n_mis = 1'b1;
            end else begin
                n_level = w_lm1;
                case (r_op)
                    pfx_pkg::OP_SUB: n_tos = r_rd - r_tos;
                    pfx_pkg::OP_MUL: n_tos = w_prod;
                    pfx_pkg::OP_DIV, pfx_pkg::OP_REM: begin
                        // A nonzero divisor leaves r_tos for the divider to replace.
                        if (r_tos == '0) begin
                            n_div0 = 1'b1;
                            n_tos  = '0;
                        end
                    end
                    default: n_tos = r_rd + r_tos;
                endcase
            end
        end else if (i_cmd.div_fix) begin
            if (r_isrem) begin
                n_tos = r_sl ? (~r_rem + 1'b1) : r_rem;
            end else begin
                n_tos = (r_sl ^ r_sr) ? (~r_dq + 1'b1) : r_dq;
            end
        end else if (i_cmd.finish && r_last) begin
            n_level = '0;
            n_abort = 1'b0;
            n_div0  = 1'b0;
            n_mis   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (!i_rst_n) begin
            r_level <= '0;
            r_abort <= 1'b0;
            r_div0  <= 1'b0;
            r_mis   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_abort <= n_abort;
            r_div0  <= n_div0;
            r_mis   <= n_mis;
        end
    end

    assign w_sh  = {r_rem, r_dq[DW-1]};
    assign w_sub = w_sh - {1'b0, r_b};
    assign w_ge  = (w_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_dq    <= w_lmag;
            r_rem   <= '0;
            r_b     <= w_rmag;
            r_cnt   <= '0;
            r_sl    <= r_rd[DW-1];
            r_sr    <= r_tos[DW-1];
            r_isrem <= (r_op == pfx_pkg::OP_REM);
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
            r_dq  <= {r_dq[DW-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_last) begin
            if (r_abort) begin
                r_out_value <= '0;
                r_out_cause <= pfx_pkg::CAUSE_NONNUM;
            end else begin
                r_out_value <= (r_level == '0) ? '0 : r_tos;
                if (r_mis || (r_level == '0)) begin
                    r_out_cause <= pfx_pkg::CAUSE_MISUSE;
                end else if (r_div0) begin
                    r_out_cause <= pfx_pkg::CAUSE_DIV0;
                end else begin
                    r_out_cause <= pfx_pkg::CAUSE_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_cause = r_out_cause;

endmodule

// ===== rtl/postfix_integer_evaluator.sv =====
// Top level of the postfix integer evaluator: controller plus datapath.
//
// Input words arrive on i_item, one expression item per word: an operand
// push (kind 0) or an operator (kind 1) that pops two entries and pushes
// the result. The word with last set closes the expression; one result
// word then appears on o_result with the top of stack, ok and a cause
// code, and the stack and error flags are cleared for the next expression.
// An input word is accepted when valid and ready are both high; ready is
// high only while the controller is idle, so one item is worked at a time.
// A push, add, subtract or multiply passes through capture, execute and
// finish between acceptance and the next ready. Divide and remainder
// with a nonzero divisor add a sign fix-up after the steps of the radix-2
// divider, which retires one quotient bit per cycle. A result word is
// visible the cycle after its final item finishes. The result sits in its
// own register, so new items are taken while it waits; only a following
// final item waits in the finish step if the receiver still stalls.
// Reset is synchronous and active low; it empties the stack, clears the
// flags and drops the result valid. Stack contents need no reset.
module postfix_integer_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfx_item_if.sink     i_item,
    pfx_result_if.source o_result
);

    pfx_pkg::t_cmd w_cmd;
    pfx_pkg::t_sts w_sts;
    logic          w_ready;
    logic [pfx_pkg::DATA_W-1:0]  w_value;
    logic [pfx_pkg::CAUSE_W-1:0] w_cause;

    // The controller owns input ready and steps the datapath.
    pfx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pfx_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_item.kind),
        .i_operand_value (i_item.operand_value),
        .i_is_number     (i_item.is_number),
        .i_op_code       (i_item.op_code),
        .i_last          (i_item.last),
        .o_valid         (o_result.valid),
        .i_ready         (o_result.ready),
        .o_value         (w_value),
        .o_cause         (w_cause)
    );

    assign i_item.ready   = w_ready;
    assign o_result.value = w_value;
    assign o_result.cause = w_cause;
    // Ok is derived from the cause so the two can never disagree.
    assign o_result.ok    = (w_cause == pfx_pkg::CAUSE_NONE);

endmodule

// ===== rtl/pfx_checker.sv =====
// Port-level checker for the postfix integer evaluator, with its bind.
module pfx_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic        [pfx_pkg::DATA_W-1:0]  i_out_value,
    input logic                               i_out_ok,
    input logic        [pfx_pkg::CAUSE_W-1:0] i_out_cause
);

    // Ok and cause must agree on every result word.
    a_ok_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_ok == (i_out_cause == pfx_pkg::CAUSE_NONE)))
        else $error("ok does not match cause");

    // An aborted expression reports zero.
    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_cause == pfx_pkg::CAUSE_NONNUM)) |-> (i_out_value == '0))
        else $error("aborted expression with nonzero value");

    // Items are worked one at a time: no acceptance in the cycle after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_value)
                                           && $stable(i_out_cause)))
        else $error("stalled result changed");

    // Reset drops the result valid.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind postfix_integer_evaluator pfx_checker u_pfx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.value),
    .i_out_ok    (o_result.ok),
    .i_out_cause (o_result.cause)
);
